/* rtl/cre_pkg.sv */
package cre_pkg;

   localparam int MAX_LEN    = 32;
   localparam int ELEM_WIDTH = 32;
   localparam int LEN_WIDTH  = $clog2(MAX_LEN + 1);
   localparam int IDX_WIDTH  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   localparam logic [1:0] ACT_APPEND_A = 2'd0;
   localparam logic [1:0] ACT_APPEND_B = 2'd1;
   localparam logic [1:0] ACT_COMPARE  = 2'd2;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [LEN_WIDTH-1:0]  len_type;
   typedef logic [IDX_WIDTH-1:0]  idx_type;

   typedef struct packed {
      logic    load_a;
      logic    load_b;
      logic    rotate;
      len_type len_a;
      len_type len_b;
      len_type last;
   } cell_ctrl_type;

endpackage

/* rtl/cyclic_rotation_equality.sv */
// Cyclic rotation equality check.
// Input beats on req_*: tuser carries the action (append to A, append to B,
// compare), tdata the element. Appends give no result; an append to a full
// store is dropped and flagged. A compare gives one beat on rsp_*: bit 0
// says whether B is a cyclic rotation of A, bit 1 whether any append was
// dropped since the last compare. The compare then clears both lengths and
// the flag.
// Each element pair sits in one cell of a row of MAX_LEN cells; a compare
// tests all cells at once, then rotates B one cell along the row per cycle.
// A compare keeps req_tready low while B rotates through the row until a
// match is found or all len rotations are tried; unequal lengths end it
// with no rotation.
// The result waits in an output register, so appends are accepted while it
// is stalled; a further compare finishes only once the held beat is taken.
// Reset empties both stores, clears the flag and drops any pending result.
module cyclic_rotation_equality (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [1:0]  req_tuser,  // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [0] identical, [1] overflow, [7:2] zero
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   cre_pkg::len_type len_a_ff, len_a_in;
   cre_pkg::len_type len_b_ff, len_b_in;
   cre_pkg::len_type step_ff, step_in;
   logic             drop_ff, drop_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ident_ff, rsp_ident_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   cre_pkg::cell_ctrl_type ctrl;
   cre_pkg::elem_type      value;
   cre_pkg::elem_type      b_vec [cre_pkg::MAX_LEN];
   logic [cre_pkg::MAX_LEN-1:0] eq_vec;

   logic accept, slot_free, done, finish, all_eq;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign done       = (len_a_ff != len_b_ff) || found_ff || (step_ff == len_a_ff);
   assign finish     = (state_ff == ST_RUN) && done && slot_free;
   assign all_eq     = &eq_vec;
   assign value      = cre_pkg::ELEM_WIDTH'(req_tdata);

   always_comb begin
      ctrl.load_a = accept && (req_tuser == cre_pkg::ACT_APPEND_A)
                    && (len_a_ff < cre_pkg::LEN_WIDTH'(cre_pkg::MAX_LEN));
      ctrl.load_b = accept && (req_tuser == cre_pkg::ACT_APPEND_B)
                    && (len_b_ff < cre_pkg::LEN_WIDTH'(cre_pkg::MAX_LEN));
      ctrl.rotate = (state_ff == ST_RUN) && !done;
      ctrl.len_a  = len_a_ff;
      ctrl.len_b  = len_b_ff;
      ctrl.last   = len_a_ff - cre_pkg::LEN_WIDTH'(1);
   end

   for (genvar i = 0; i < cre_pkg::MAX_LEN; i++) begin : g_cell
      cre_pkg::elem_type nb;
      if (i == cre_pkg::MAX_LEN - 1) begin : g_end
         assign nb = b_vec[0];
      end else begin : g_mid
         assign nb = b_vec[i+1];
      end
      cre_cell u_cell (
         .clock  (clock),
         .ctrl   (ctrl),
         .idx    (cre_pkg::IDX_WIDTH'(i)),
         .value  (value),
         .b_next (nb),
         .b_wrap (b_vec[0]),
         .b_out  (b_vec[i]),
         .eq     (eq_vec[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      step_in      = step_ff;
      drop_in      = drop_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ident_in = rsp_ident_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  cre_pkg::ACT_APPEND_A: begin
                     if (ctrl.load_a) len_a_in = len_a_ff + cre_pkg::LEN_WIDTH'(1);
                     else drop_in = 1'b1;
                  end
                  cre_pkg::ACT_APPEND_B: begin
                     if (ctrl.load_b) len_b_in = len_b_ff + cre_pkg::LEN_WIDTH'(1);
                     else drop_in = 1'b1;
                  end
                  cre_pkg::ACT_COMPARE: begin
                     state_in = ST_RUN;
                     step_in  = '0;
                     found_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (ctrl.rotate) begin
               found_in = all_eq;
               step_in  = step_ff + cre_pkg::LEN_WIDTH'(1);
            end
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_ident_in = (len_a_ff == len_b_ff)
                              && (found_ff || (len_a_ff == '0));
               rsp_ovf_in   = drop_ff;
               len_a_in     = '0;
               len_b_in     = '0;
               drop_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         drop_ff      <= 1'b0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         drop_ff      <= drop_in;
         found_ff     <= found_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ident_ff <= rsp_ident_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_ident_ff};

endmodule

/* rtl/cre_cell.sv */
module cre_cell (
   input  logic                   clock,
   input  cre_pkg::cell_ctrl_type ctrl,
   input  cre_pkg::idx_type       idx,
   input  cre_pkg::elem_type      value,
   input  cre_pkg::elem_type      b_next,
   input  cre_pkg::elem_type      b_wrap,
   output cre_pkg::elem_type      b_out,
   output logic                   eq
);

   cre_pkg::elem_type a_ff, a_in;
   cre_pkg::elem_type b_ff, b_in;
   cre_pkg::len_type  my_pos;

   assign my_pos = cre_pkg::LEN_WIDTH'(idx);

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctrl.load_a && (ctrl.len_a == my_pos)) begin
         a_in = value;
      end
      priority if (ctrl.rotate) begin
         b_in = (my_pos == ctrl.last) ? b_wrap : b_next;
      end else if (ctrl.load_b && (ctrl.len_b == my_pos)) begin
         b_in = value;
      end else begin
         b_in = b_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign b_out = b_ff;
   assign eq    = (my_pos >= ctrl.len_a) || (a_ff == b_ff);

endmodule
